>>> design/mfc_pkg.sv
// Package for the metaball field classifier: sizes, request and class codes,
// the ball record type and the class colors. No dependencies.
package mfc_pkg;

    localparam int SCREEN_WIDTH  = 480;
    localparam int SCREEN_HEIGHT = 272;
    localparam int BALL_COUNT    = 4;
    localparam int NBALLS        = 4;
    localparam int FRAC_BITS     = 12;

    localparam int POS_W   = 12;
    localparam int VEL_W   = 4;
    localparam int SIZE_W  = 6;
    localparam int PIX_W   = 9;
    localparam int REQ_W   = 2;
    localparam int SUM_W   = 16;
    localparam int QBITS   = SUM_W;
    localparam int SETUP_W = 38;
    localparam int CIDX_W  = 3;
    localparam int RGB_W   = 24;

    localparam int DX_W  = POS_W + 1;
    localparam int SQ_W  = 2 * DX_W;
    localparam int D2_W  = SQ_W + 1;
    localparam int RR_W  = 2 * SIZE_W;
    localparam int NUM_W = RR_W + FRAC_BITS;
    localparam int CMP_W = D2_W + QBITS;

    // Register stages inside one ball lane: difference, squares, setup, divide.
    localparam int LANE_LAT = QBITS + 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_PIXEL  = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_RELOAD = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CLS_BACKGROUND = 2'd0,
        CLS_GREEN      = 2'd1,
        CLS_WHITE      = 2'd2,
        CLS_BLACK      = 2'd3
    } t_class;

    localparam logic [CIDX_W-1:0] CFG_LEVEL_BLACK = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_LEVEL_WHITE = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_LEVEL_GREEN = 3'd6;

    localparam logic [SUM_W-1:0] LEVEL_BLACK_RST = 16'd2662;
    localparam logic [SUM_W-1:0] LEVEL_WHITE_RST = 16'd2048;
    localparam logic [SUM_W-1:0] LEVEL_GREEN_RST = 16'd1638;

    localparam logic [RGB_W-1:0] RGB_DARK  = 24'h000000;
    localparam logic [RGB_W-1:0] RGB_GREEN = 24'h00FF00;
    localparam logic [RGB_W-1:0] RGB_WHITE = 24'hFFFFFF;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic        [SIZE_W-1:0] size;
    } t_ball;

endpackage

>>> design/metaball_field_classifier.sv
// A pixel request shows its result after 19 lane stages, two summing stages
// and the output register. Throughput: one request per cycle unless the output
// stalls; the ball lanes divide one quotient bit per stage.
// Tick and reload requests give no result.
// Reset (synchronous, active low) clears balls, setup registers, valid bits
// and restores the default thresholds.
module metaball_field_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mfc_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [mfc_pkg::SETUP_W-1:0]     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mfc_pkg::REQ_W-1:0]       i_req_type,
    input  logic [mfc_pkg::PIX_W-1:0]       i_pixel_x,
    input  logic [mfc_pkg::PIX_W-1:0]       i_pixel_y,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mfc_pkg::PIX_W-1:0]       o_out_x,
    output logic [mfc_pkg::PIX_W-1:0]       o_out_y,
    output logic [mfc_pkg::SUM_W-1:0]       o_field_sum,
    output logic [1:0]                      o_pixel_class,
    output logic [mfc_pkg::RGB_W-1:0]       o_pixel_rgb
);

    // The whole pipeline moves together; it holds only when the output
    // register is full and the consumer is not taking it.
    logic en;
    logic accept;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign accept  = i_valid && o_ready;

    // Setup registers and thresholds.
    logic [mfc_pkg::SETUP_W-1:0] r_setup [0:mfc_pkg::NBALLS-1];
    logic [mfc_pkg::SUM_W-1:0]   r_lvl_black, r_lvl_white, r_lvl_green;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mfc_pkg::NBALLS; i++) r_setup[i] <= '0;
            r_lvl_black <= mfc_pkg::LEVEL_BLACK_RST;
            r_lvl_white <= mfc_pkg::LEVEL_WHITE_RST;
            r_lvl_green <= mfc_pkg::LEVEL_GREEN_RST;
        end else if (i_cfg_we) begin
            for (int i = 0; i < mfc_pkg::NBALLS; i++) begin
                if (i_cfg_index == mfc_pkg::CIDX_W'(i)) r_setup[i] <= i_cfg_data;
            end
            if (i_cfg_index == mfc_pkg::CFG_LEVEL_BLACK)
                r_lvl_black <= i_cfg_data[mfc_pkg::SUM_W-1:0];
            if (i_cfg_index == mfc_pkg::CFG_LEVEL_WHITE)
                r_lvl_white <= i_cfg_data[mfc_pkg::SUM_W-1:0];
            if (i_cfg_index == mfc_pkg::CFG_LEVEL_GREEN)
                r_lvl_green <= i_cfg_data[mfc_pkg::SUM_W-1:0];
        end
    end

    // Ball state. A tick moves each active ball and reflects its velocity once
    // the position goes below 0 or above the screen size; a reload copies the setup.
    mfc_pkg::t_ball r_ball [0:mfc_pkg::NBALLS-1];
    mfc_pkg::t_ball n_ball [0:mfc_pkg::NBALLS-1];

    always_comb begin
        for (int i = 0; i < mfc_pkg::NBALLS; i++) begin
            n_ball[i] = r_ball[i];
            if (accept && i_req_type == mfc_pkg::REQ_TICK && i < mfc_pkg::BALL_COUNT) begin
                n_ball[i].pos_x = r_ball[i].pos_x + mfc_pkg::POS_W'(r_ball[i].vel_x);
                n_ball[i].pos_y = r_ball[i].pos_y + mfc_pkg::POS_W'(r_ball[i].vel_y);
                if (n_ball[i].pos_x < 0 ||
                    n_ball[i].pos_x > mfc_pkg::POS_W'(mfc_pkg::SCREEN_WIDTH))
                    n_ball[i].vel_x = -r_ball[i].vel_x;
                if (n_ball[i].pos_y < 0 ||
                    n_ball[i].pos_y > mfc_pkg::POS_W'(mfc_pkg::SCREEN_HEIGHT))
                    n_ball[i].vel_y = -r_ball[i].vel_y;
            end else if (accept && i_req_type == mfc_pkg::REQ_RELOAD) begin
                n_ball[i].pos_x = r_setup[i][11:0];
                n_ball[i].pos_y = r_setup[i][23:12];
                n_ball[i].vel_x = r_setup[i][27:24];
                n_ball[i].vel_y = r_setup[i][31:28];
                n_ball[i].size  = r_setup[i][37:32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mfc_pkg::NBALLS; i++) r_ball[i] <= '0;
        end else begin
            for (int i = 0; i < mfc_pkg::NBALLS; i++) r_ball[i] <= n_ball[i];
        end
    end

    // Ball lanes. Each captures the ball state at acceptance, so a tick that
    // follows a pixel request does not disturb it.
    logic [mfc_pkg::SUM_W-1:0] lane_term [0:mfc_pkg::NBALLS-1];
    logic [mfc_pkg::SUM_W-1:0] term      [0:mfc_pkg::NBALLS-1];

    for (genvar g = 0; g < mfc_pkg::NBALLS; g++) begin : g_lane
        mfc_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_pix_x (i_pixel_x),
            .i_pix_y (i_pixel_y),
            .i_ball  (r_ball[g]),
            .o_term  (lane_term[g])
        );
        assign term[g] = (g < mfc_pkg::BALL_COUNT) ? lane_term[g] : '0;
    end

    // Valid bits and echoed coordinates travel beside the lanes.
    logic                       r_vld [0:mfc_pkg::LANE_LAT-1];
    logic [mfc_pkg::PIX_W-1:0]  r_px  [0:mfc_pkg::LANE_LAT-1];
    logic [mfc_pkg::PIX_W-1:0]  r_py  [0:mfc_pkg::LANE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < mfc_pkg::LANE_LAT; s++) r_vld[s] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid && i_req_type == mfc_pkg::REQ_PIXEL;
            for (int s = 1; s < mfc_pkg::LANE_LAT; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px[0] <= i_pixel_x;
            r_py[0] <= i_pixel_y;
            for (int s = 1; s < mfc_pkg::LANE_LAT; s++) begin
                r_px[s] <= r_px[s-1];
                r_py[s] <= r_py[s-1];
            end
        end
    end

    // Summing tree. All terms are non-negative, so clamping the total once
    // equals clamping after every addition.
    logic                        r_vld_a, r_vld_b;
    logic [mfc_pkg::SUM_W:0]     r_pair0, r_pair1;
    logic [mfc_pkg::PIX_W-1:0]   r_px_a, r_py_a, r_px_b, r_py_b;
    logic [mfc_pkg::SUM_W-1:0]   r_sum_b;
    logic [mfc_pkg::SUM_W+1:0]   n_total;
    logic [1:0]                  n_class;
    logic [mfc_pkg::RGB_W-1:0]   n_rgb;

    assign n_total = (mfc_pkg::SUM_W+2)'(r_pair0) + (mfc_pkg::SUM_W+2)'(r_pair1);

    always_comb begin
        if (r_sum_b > r_lvl_black) begin
            n_class = mfc_pkg::CLS_BLACK;
        end else if (r_sum_b > r_lvl_white) begin
            n_class = mfc_pkg::CLS_WHITE;
        end else if (r_sum_b > r_lvl_green) begin
            n_class = mfc_pkg::CLS_GREEN;
        end else begin
            n_class = mfc_pkg::CLS_BACKGROUND;
        end
        case (n_class)
            mfc_pkg::CLS_GREEN: n_rgb = mfc_pkg::RGB_GREEN;
            mfc_pkg::CLS_WHITE: n_rgb = mfc_pkg::RGB_WHITE;
            default:            n_rgb = mfc_pkg::RGB_DARK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_vld_a <= r_vld[mfc_pkg::LANE_LAT-1];
            r_vld_b <= r_vld_a;
            o_valid <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pair0 <= (mfc_pkg::SUM_W+1)'(term[0]) + (mfc_pkg::SUM_W+1)'(term[1]);
            r_pair1 <= (mfc_pkg::SUM_W+1)'(term[2]) + (mfc_pkg::SUM_W+1)'(term[3]);
            r_px_a  <= r_px[mfc_pkg::LANE_LAT-1];
            r_py_a  <= r_py[mfc_pkg::LANE_LAT-1];
            r_sum_b <= (n_total > (mfc_pkg::SUM_W+2)'({mfc_pkg::SUM_W{1'b1}})) ?
                       '1 : n_total[mfc_pkg::SUM_W-1:0];
            r_px_b  <= r_px_a;
            r_py_b  <= r_py_a;
            o_out_x       <= r_px_b;
            o_out_y       <= r_py_b;
            o_field_sum   <= r_sum_b;
            o_pixel_class <= n_class;
            o_pixel_rgb   <= n_rgb;
        end
    end

endmodule

>>> design/mfc_lane.sv
// One ball lane of the metaball field classifier: distance, squares and a
// restoring divider with one quotient bit per stage. Depends on mfc_pkg.
module mfc_lane (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [mfc_pkg::PIX_W-1:0]      i_pix_x,
    input  logic [mfc_pkg::PIX_W-1:0]      i_pix_y,
    input  mfc_pkg::t_ball                 i_ball,
    output logic [mfc_pkg::SUM_W-1:0]      o_term
);

    logic signed [mfc_pkg::DX_W-1:0]  r_dx, r_dy, n_dx, n_dy;
    logic [mfc_pkg::SIZE_W-1:0]       r_size;
    logic [mfc_pkg::SQ_W-1:0]         r_sqx, r_sqy;
    logic [mfc_pkg::RR_W-1:0]         r_rr;
    logic [mfc_pkg::D2_W-1:0]         n_d2;
    logic [mfc_pkg::NUM_W-1:0]        n_num;
    logic                             n_sat;

    logic [mfc_pkg::D2_W-1:0]  r_den [0:mfc_pkg::QBITS];
    logic [mfc_pkg::NUM_W-1:0] r_rem [0:mfc_pkg::QBITS];
    logic [mfc_pkg::QBITS-1:0] r_q   [0:mfc_pkg::QBITS];
    logic                      r_sat [0:mfc_pkg::QBITS];

    always_comb begin
        n_dx  = mfc_pkg::DX_W'($signed({1'b0, i_pix_x})) - mfc_pkg::DX_W'(i_ball.pos_x);
        n_dy  = mfc_pkg::DX_W'($signed({1'b0, i_pix_y})) - mfc_pkg::DX_W'(i_ball.pos_y);
        n_d2  = mfc_pkg::D2_W'(r_sqx) + mfc_pkg::D2_W'(r_sqy);
        n_num = mfc_pkg::NUM_W'(r_rr) << mfc_pkg::FRAC_BITS;
        // A quotient of 2^16 or more, and a zero distance, both clamp.
        n_sat = (n_d2 == '0) ||
                (mfc_pkg::CMP_W'(n_num) >= (mfc_pkg::CMP_W'(n_d2) << mfc_pkg::QBITS));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_size   <= i_ball.size;
            r_sqx    <= mfc_pkg::SQ_W'(r_dx * r_dx);
            r_sqy    <= mfc_pkg::SQ_W'(r_dy * r_dy);
            r_rr     <= mfc_pkg::RR_W'(r_size * r_size);
            r_den[0] <= n_d2;
            r_rem[0] <= n_num;
            r_q[0]   <= '0;
            r_sat[0] <= n_sat;
            for (int k = 0; k < mfc_pkg::QBITS; k++) begin
                r_den[k+1] <= r_den[k];
                r_sat[k+1] <= r_sat[k];
                r_q[k+1]   <= r_q[k];
                if (mfc_pkg::CMP_W'(r_rem[k]) >=
                    (mfc_pkg::CMP_W'(r_den[k]) << (mfc_pkg::QBITS - 1 - k))) begin
                    r_rem[k+1] <= mfc_pkg::NUM_W'(mfc_pkg::CMP_W'(r_rem[k]) -
                        (mfc_pkg::CMP_W'(r_den[k]) << (mfc_pkg::QBITS - 1 - k)));
                    r_q[k+1][mfc_pkg::QBITS-1-k] <= 1'b1;
                end else begin
                    r_rem[k+1] <= r_rem[k];
                end
            end
        end
    end

    assign o_term = r_sat[mfc_pkg::QBITS] ? '1 : r_q[mfc_pkg::QBITS];

endmodule

>>> design/mfc_checker.sv
// Port-level checker for the metaball field classifier and its bind.
// Depends on mfc_pkg and the top level's ports.
module mfc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [mfc_pkg::PIX_W-1:0]       o_out_x,
    input logic [mfc_pkg::SUM_W-1:0]       o_field_sum,
    input logic [1:0]                      o_pixel_class,
    input logic [mfc_pkg::RGB_W-1:0]       o_pixel_rgb
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_field_sum) && $stable(o_out_x))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("request refused with empty output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    a_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_class == mfc_pkg::CLS_GREEN && o_pixel_rgb == mfc_pkg::RGB_GREEN)
                 || (o_pixel_class == mfc_pkg::CLS_WHITE && o_pixel_rgb == mfc_pkg::RGB_WHITE)
                 || (o_pixel_class == mfc_pkg::CLS_BLACK && o_pixel_rgb == mfc_pkg::RGB_DARK)
                 || (o_pixel_class == mfc_pkg::CLS_BACKGROUND
                     && o_pixel_rgb == mfc_pkg::RGB_DARK))
        else $error("color does not match class");

endmodule

bind metaball_field_classifier mfc_checker u_mfc_checker (.*);
